// ===== rtl/core/id3tfe_pkg.sv =====
package id3tfe_pkg;

	// Parse phases
	localparam logic [2:0] PH_HDR      = 3'd0;
	localparam logic [2:0] PH_EXT_SIZE = 3'd1;
	localparam logic [2:0] PH_EXT_SKIP = 3'd2;
	localparam logic [2:0] PH_FHDR     = 3'd3;
	localparam logic [2:0] PH_FPAY     = 3'd4;
	localparam logic [2:0] PH_DONE     = 3'd5;
	localparam logic [2:0] PH_ERR      = 3'd6;

	// Result kinds
	localparam logic [1:0] KIND_TEXT  = 2'd0;
	localparam logic [1:0] KIND_EMPTY = 2'd1;
	localparam logic [1:0] KIND_DONE  = 2'd2;
	localparam logic [1:0] KIND_ERROR = 2'd3;

	// Field ids
	localparam logic [1:0] FID_TITLE  = 2'd0;
	localparam logic [1:0] FID_ALBUM  = 2'd1;
	localparam logic [1:0] FID_ARTIST = 2'd2;

	localparam logic [7:0]  BYTE_T     = 8'h54;
	localparam logic [23:0] ID_IT2     = 24'h495432;
	localparam logic [23:0] ID_ALB     = 24'h414C42;
	localparam logic [23:0] ID_PE1     = 24'h504531;
	localparam logic [7:0]  HDR_UNSYNC_BIT = 8'b1000_0000;
	localparam logic [7:0]  FLAG_EXT    = 8'b0100_0000;
	localparam logic [7:0]  FLAG_SKIP   = 8'b1100_0000;
	localparam logic [28:0] HDR_LEN     = 29'd10;

	// Result queue geometry
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  fid;
		logic [7:0]  tbyte;
		logic        last;
		logic [28:0] total;
	} result_t;

	typedef struct packed {
		logic [2:0]  phase;
		logic [3:0]  header_index;
		logic [27:0] tag_size;
		logic [27:0] payload_offset;
		logic        unsync_flag;
		logic        ext_header_flag;
		logic [31:0] size_acc;
		logic [27:0] skip_target;
		logic [3:0]  fhdr_index;
		logic [23:0] frame_id;
		logic [31:0] frame_remaining;
		logic        frame_skip;
		logic [1:0]  selected_field;
		logic        stripping_zeros;
	} parse_st_t;

	localparam parse_st_t ST_RESET = '{
		phase: PH_HDR, header_index: 4'd0, tag_size: 28'd0, payload_offset: 28'd0,
		unsync_flag: 1'b0, ext_header_flag: 1'b0, size_acc: 32'd0, skip_target: 28'd0,
		fhdr_index: 4'd0, frame_id: 24'd0, frame_remaining: 32'd0, frame_skip: 1'b0,
		selected_field: FID_TITLE, stripping_zeros: 1'b1
	};

	// Drop the top bit of each byte and pack the 7-bit groups
	function automatic logic [27:0] desync(input logic [31:0] a);
		desync = {a[30:24], a[22:16], a[14:8], a[6:0]};
	endfunction

endpackage

// ===== rtl/core/id3v2_text_frame_extractor_core.sv =====
// Channel | Direction | Handshake          | Word
// input   | in        | in_valid/in_stall   | tag_byte, first_byte
// output  | out       | out_valid/out_stall | result_kind, field_id, text_byte,
//         |           |                     | frame_last, tag_total_size
//
// One tag byte is taken per cycle while in_stall is low; its results land in the result
// queue at the same edge and can leave from the next cycle, one word per cycle while out_stall is low.
// A byte can give up to two results; in_stall rises while the four-entry
// result queue has fewer than two free entries.
// arst_n clears the parse state to the header phase and empties the queue.
// out_stall only holds the queue head; parsing runs on while space remains.
module id3v2_text_frame_extractor_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  tag_byte,
	input  logic        first_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  result_kind,
	output logic [1:0]  field_id,
	output logic [7:0]  text_byte,
	output logic        frame_last,
	output logic [28:0] tag_total_size
);
	import id3tfe_pkg::*;

	parse_st_t          st_q;
	parse_st_t          st_nxt;
	logic [1:0]         res_cnt;
	result_t            res0;
	result_t            res1;
	result_t            head;
	logic [FIFO_CW-1:0] count;
	logic               in_acc;
	logic               out_acc;
	logic [1:0]         push_cnt;

	// Take a byte only while two queue entries are free
	assign in_stall = (count > FIFO_CW'(FIFO_DEPTH - 2));
	assign in_acc   = in_valid && !in_stall;
	assign out_valid = (count != '0);
	assign out_acc   = out_valid && !out_stall;
	assign push_cnt  = in_acc ? res_cnt : 2'd0;

	// Next-state and result logic for the byte at the port
	id3tfe_step u_step (
		.st         (st_q),
		.tag_byte   (tag_byte),
		.first_byte (first_byte),
		.nxt        (st_nxt),
		.res_cnt    (res_cnt),
		.res0       (res0),
		.res1       (res1)
	);

	// Advance the parse state on every accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_RESET;
		end else if (in_acc) begin
			st_q <= st_nxt;
		end
	end

	// Result queue decouples the input from output back-pressure
	id3tfe_res_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_cnt (push_cnt),
		.push0    (res0),
		.push1    (res1),
		.pop      (out_acc),
		.head     (head),
		.count    (count)
	);

	assign result_kind    = head.kind;
	assign field_id       = head.fid;
	assign text_byte      = head.tbyte;
	assign frame_last     = head.last;
	assign tag_total_size = head.total;

	a_stall_room: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> (count <= FIFO_CW'(FIFO_DEPTH - 2)))
		else $error("byte accepted without room for two results");

	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && !first_byte && (st_q.phase == PH_DONE || st_q.phase == PH_ERR))
		|-> (res_cnt == 2'd0))
		else $error("result after tag end without restart");

	a_err_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(res_cnt == 2'd2) |-> (res1.kind == KIND_DONE && res0.kind != KIND_ERROR))
		else $error("bad result pair");

endmodule

// ===== rtl/core/id3tfe_step.sv =====
module id3tfe_step (
	input  id3tfe_pkg::parse_st_t st,
	input  logic [7:0]            tag_byte,
	input  logic                  first_byte,
	output id3tfe_pkg::parse_st_t nxt,
	output logic [1:0]            res_cnt,
	output id3tfe_pkg::result_t   res0,
	output id3tfe_pkg::result_t   res1
);
	import id3tfe_pkg::*;

	parse_st_t   cur;
	logic        has_first;
	logic        has_done;
	result_t     first_res;
	result_t     done_res;
	logic [27:0] off_n;
	logic [31:0] acc_n;
	logic [3:0]  hi_n;
	logic [27:0] ext_sz;
	logic [31:0] rem_n;
	logic [32:0] frame_end;
	logic        skip_n;

	always_comb begin
		cur       = first_byte ? ST_RESET : st;
		nxt       = cur;
		has_first = 1'b0;
		has_done  = 1'b0;
		first_res = '0;
		off_n     = cur.payload_offset + 28'd1;
		acc_n     = {cur.size_acc[23:0], tag_byte};
		hi_n      = cur.header_index + 4'd1;
		ext_sz    = desync(acc_n);
		rem_n     = cur.frame_remaining - 32'd1;
		frame_end = '0;
		skip_n    = 1'b0;

		unique case (cur.phase)
			PH_HDR: begin
				if (cur.header_index == 4'd5) begin
					nxt.unsync_flag     = |(tag_byte & HDR_UNSYNC_BIT);
					nxt.ext_header_flag = |(tag_byte & FLAG_EXT);
				end
				if (cur.header_index >= 4'd6)
					nxt.size_acc = acc_n;
				if (cur.header_index >= 4'd9) begin
					nxt.tag_size     = desync(acc_n);
					nxt.size_acc     = '0;
					nxt.header_index = '0;
					if (cur.ext_header_flag) begin
						if (nxt.tag_size < 28'd4) begin
							nxt.phase  = PH_ERR;
							has_first  = 1'b1;
							first_res.kind = KIND_ERROR;
						end else begin
							nxt.phase = PH_EXT_SIZE;
						end
					end else if (nxt.tag_size == 28'd0) begin
						nxt.phase = PH_DONE;
						has_done  = 1'b1;
					end else begin
						nxt.phase = PH_FHDR;
					end
				end else begin
					nxt.header_index = hi_n;
				end
			end
			PH_EXT_SIZE: begin
				nxt.payload_offset = off_n;
				nxt.size_acc       = acc_n;
				nxt.header_index   = hi_n;
				if (hi_n >= 4'd4) begin
					nxt.skip_target  = ext_sz;
					nxt.size_acc     = '0;
					nxt.header_index = '0;
					if (ext_sz < 28'd4) begin
						nxt.phase      = PH_ERR;
						has_first      = 1'b1;
						first_res.kind = KIND_ERROR;
					end else if (off_n >= cur.tag_size) begin
						nxt.phase = PH_DONE;
						has_done  = 1'b1;
					end else begin
						nxt.phase = (ext_sz == 28'd4) ? PH_FHDR : PH_EXT_SKIP;
					end
				end
			end
			PH_EXT_SKIP: begin
				nxt.payload_offset = off_n;
				if (off_n >= cur.tag_size) begin
					nxt.phase = PH_DONE;
					has_done  = 1'b1;
				end else if (off_n >= cur.skip_target) begin
					nxt.phase = PH_FHDR;
				end
			end
			PH_FHDR: begin
				nxt.payload_offset = off_n;
				if (cur.fhdr_index >= 4'd1 && cur.fhdr_index <= 4'd3)
					nxt.frame_id = {cur.frame_id[15:0], tag_byte};
				if (cur.fhdr_index >= 4'd4 && cur.fhdr_index <= 4'd7)
					nxt.size_acc = acc_n;
				if (cur.fhdr_index == 4'd0 && tag_byte != BYTE_T) begin
					nxt.phase      = PH_ERR;
					has_first      = 1'b1;
					first_res.kind = KIND_ERROR;
				end else if (cur.fhdr_index < 4'd9) begin
					nxt.fhdr_index = cur.fhdr_index + 4'd1;
					if (off_n >= cur.tag_size) begin
						nxt.phase      = PH_ERR;
						has_first      = 1'b1;
						first_res.kind = KIND_ERROR;
					end
				end else begin
					nxt.fhdr_index      = '0;
					nxt.frame_remaining = cur.unsync_flag ? {4'd0, desync(cur.size_acc)}
					                                      : cur.size_acc;
					nxt.size_acc        = '0;
					frame_end = {5'd0, off_n} + {1'b0, nxt.frame_remaining};
					// select field by identifier; anything else is skipped
					priority if (cur.frame_id == ID_IT2) begin
						nxt.selected_field = FID_TITLE;
					end else if (cur.frame_id == ID_ALB) begin
						nxt.selected_field = FID_ALBUM;
					end else if (cur.frame_id == ID_PE1) begin
						nxt.selected_field = FID_ARTIST;
					end else begin
						nxt.selected_field = FID_TITLE;
						skip_n = 1'b1;
					end
					if (|(tag_byte & FLAG_SKIP))
						skip_n = 1'b1;
					nxt.frame_skip      = skip_n;
					nxt.stripping_zeros = 1'b1;
					if (frame_end > {5'd0, cur.tag_size}) begin
						nxt.phase      = PH_ERR;
						has_first      = 1'b1;
						first_res.kind = KIND_ERROR;
					end else if (nxt.frame_remaining == 32'd0) begin
						if (!skip_n) begin
							has_first      = 1'b1;
							first_res.kind = KIND_EMPTY;
							first_res.fid  = nxt.selected_field;
						end
						if (off_n >= cur.tag_size) begin
							nxt.phase = PH_DONE;
							has_done  = 1'b1;
						end
					end else begin
						nxt.phase = PH_FPAY;
					end
				end
			end
			PH_FPAY: begin
				nxt.payload_offset  = off_n;
				nxt.frame_remaining = rem_n;
				if (!cur.frame_skip) begin
					if (cur.stripping_zeros && tag_byte == 8'd0) begin
						if (rem_n == 32'd0) begin
							has_first      = 1'b1;
							first_res.kind = KIND_EMPTY;
							first_res.fid  = cur.selected_field;
						end
					end else begin
						nxt.stripping_zeros = 1'b0;
						has_first       = 1'b1;
						first_res.kind  = KIND_TEXT;
						first_res.fid   = cur.selected_field;
						first_res.tbyte = tag_byte;
						first_res.last  = (rem_n == 32'd0);
					end
				end
				if (rem_n == 32'd0) begin
					if (off_n >= cur.tag_size) begin
						nxt.phase = PH_DONE;
						has_done  = 1'b1;
					end else begin
						nxt.phase = PH_FHDR;
					end
				end
			end
			default: begin
				// done or error: hold until the next first byte
			end
		endcase

		done_res       = '0;
		done_res.kind  = KIND_DONE;
		done_res.total = {1'b0, nxt.tag_size} + HDR_LEN;
	end

	assign res_cnt = {1'b0, has_first} + {1'b0, has_done};
	assign res0    = has_first ? first_res : done_res;
	assign res1    = done_res;

endmodule

// ===== rtl/core/id3tfe_res_fifo.sv =====
module id3tfe_res_fifo (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [1:0]                       push_cnt,
	input  id3tfe_pkg::result_t              push0,
	input  id3tfe_pkg::result_t              push1,
	input  logic                             pop,
	output id3tfe_pkg::result_t              head,
	output logic [id3tfe_pkg::FIFO_CW-1:0]   count
);
	import id3tfe_pkg::*;

	result_t              mem [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wr_ptr_q;
	logic [FIFO_AW-1:0]   rd_ptr_q;
	logic [FIFO_CW-1:0]   count_q;
	logic [FIFO_AW-1:0]   wr_ptr_p1;

	assign wr_ptr_p1 = wr_ptr_q + FIFO_AW'(1);

	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0)
			mem[wr_ptr_q] <= push0;
		if (push_cnt == 2'd2)
			mem[wr_ptr_p1] <= push1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_AW'(push_cnt);
			if (pop)
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			count_q <= count_q + FIFO_CW'(push_cnt) - FIFO_CW'(pop);
		end
	end

	assign head  = mem[rd_ptr_q];
	assign count = count_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FIFO_CW'(FIFO_DEPTH))
		else $error("result queue count beyond depth");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, count_q} + (FIFO_CW+1)'(push_cnt)) <=
		((FIFO_CW+1)'(FIFO_DEPTH) + (FIFO_CW+1)'(pop)))
		else $error("result queue overflow");

	a_push_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		push_cnt != 2'd3)
		else $error("more than two results pushed");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(push_cnt == 2'd0 && !pop) |=> $stable(count_q))
		else $error("queue count moved without push or pop");

endmodule

// ===== tb/sv/tb.sv =====
module tb;
	import id3tfe_pkg::*;

	localparam int ITEMS     = 1950;
	localparam int LONG_HOLD = 300;
	localparam int TAIL      = 16;

	// Second frame flag bits that make a frame skipped
	localparam logic [7:0]  FL2_COMPRESSED = 8'h80;
	localparam logic [7:0]  FL2_ENCRYPTED  = 8'h40;
	localparam logic [23:0] ID_XXX         = 24'h585858;

	class tag_parse_scoreboard;
		result_t parsed_results[$];
		int unsigned errors;
		logic [2:0] phase;
		logic [3:0] hdr_idx, fh_idx;
		logic [31:0] tag_len, offset, acc, ext_len, remain;
		logic unsync, ext, skip, stripping;
		logic [23:0] frame_id;
		logic [1:0] field;

		function new();
			errors = 0;
			clear();
		endfunction

		function void clear();
			phase = PH_HDR;
			hdr_idx = '0;
			fh_idx = '0;
			tag_len = '0;
			offset = '0;
			acc = '0;
			ext_len = '0;
			remain = '0;
			unsync = 1'b0;
			ext = 1'b0;
			skip = 1'b0;
			stripping = 1'b1;
			frame_id = '0;
			field = FID_TITLE;
		endfunction

		function logic [31:0] unpack7(input logic [31:0] a);
			logic [31:0] v;
			v = '0;
			for (int i = 0; i < 4; i++)
				v = v | (32'(a[8 * i +: 7]) << (7 * i));
			return v;
		endfunction

		function void add(input logic [1:0] kind, input logic [1:0] fid, input logic [7:0] tb,
				input logic last, input logic [28:0] total);
			result_t w;
			w.kind = kind;
			w.fid = fid;
			w.tbyte = tb;
			w.last = last;
			w.total = total;
			parsed_results.push_back(w);
		endfunction

		function void give_error();
			phase = PH_ERR;
			add(KIND_ERROR, FID_TITLE, 8'h00, 1'b0, 29'd0);
		endfunction

		function void give_done();
			phase = PH_DONE;
			add(KIND_DONE, FID_TITLE, 8'h00, 1'b0, 29'(tag_len + 32'd10));
		endfunction

		// Advance the parse by one accepted byte and queue what it yields
		function void take_byte(input logic [7:0] b, input logic first);
			logic [3:0] k;
			logic [32:0] reach;
			if (first)
				clear();
			case (phase)
				PH_HDR: begin
					if (hdr_idx == 5) begin
						unsync = b[7];
						ext = b[6];
					end
					if (hdr_idx >= 6)
						acc = {acc[23:0], b};
					if (hdr_idx >= 9) begin
						tag_len = unpack7(acc);
						acc = '0;
						hdr_idx = '0;
						if (ext) begin
							if (tag_len < 4)
								give_error();
							else
								phase = PH_EXT_SIZE;
						end else if (tag_len == 0) begin
							give_done();
						end else begin
							phase = PH_FHDR;
						end
					end else begin
						hdr_idx++;
					end
				end
				PH_EXT_SIZE: begin
					offset++;
					acc = {acc[23:0], b};
					hdr_idx++;
					if (hdr_idx < 4)
						return;
					ext_len = unpack7(acc);
					acc = '0;
					hdr_idx = '0;
					if (ext_len < 4)
						give_error();
					else if (offset >= tag_len)
						give_done();
					else
						phase = (ext_len == 4) ? PH_FHDR : PH_EXT_SKIP;
				end
				PH_EXT_SKIP: begin
					offset++;
					if (offset >= tag_len)
						give_done();
					else if (offset >= ext_len)
						phase = PH_FHDR;
				end
				PH_FHDR: begin
					k = fh_idx;
					offset++;
					if (k == 0 && b != BYTE_T) begin
						give_error();
						return;
					end
					if (k >= 1 && k <= 3)
						frame_id = {frame_id[15:0], b};
					if (k >= 4 && k <= 7)
						acc = {acc[23:0], b};
					if (k < 9) begin
						if (offset >= tag_len)
							give_error();
						else
							fh_idx = k + 4'd1;
						return;
					end
					fh_idx = '0;
					remain = unsync ? unpack7(acc) : acc;
					acc = '0;
					reach = 33'(offset) + 33'(remain);
					if (reach > 33'(tag_len)) begin
						give_error();
						return;
					end
					skip = 1'b0;
					case (frame_id)
						ID_IT2: field = FID_TITLE;
						ID_ALB: field = FID_ALBUM;
						ID_PE1: field = FID_ARTIST;
						default: begin
							field = FID_TITLE;
							skip = 1'b1;
						end
					endcase
					if ((b & FLAG_SKIP) != 0)
						skip = 1'b1;
					stripping = 1'b1;
					if (remain == 0) begin
						if (!skip)
							add(KIND_EMPTY, field, 8'h00, 1'b0, 29'd0);
						if (offset >= tag_len)
							give_done();
						return;
					end
					phase = PH_FPAY;
				end
				PH_FPAY: begin
					offset++;
					remain--;
					if (!skip) begin
						if (stripping && b == 8'h00) begin
							if (remain == 0)
								add(KIND_EMPTY, field, 8'h00, 1'b0, 29'd0);
						end else begin
							stripping = 1'b0;
							add(KIND_TEXT, field, b, remain == 0, 29'd0);
						end
					end
					if (remain == 0) begin
						if (offset >= tag_len)
							give_done();
						else
							phase = PH_FHDR;
					end
				end
				default: ;
			endcase
		endfunction

		function int pending();
			return parsed_results.size();
		endfunction

		function void cmp_field(input string name, input int unsigned want, input int unsigned got);
			if (want != got) begin
				$display("%0t: %s expected %0d got %0d", $time, name, want, got);
				errors++;
			end
		endfunction

		function void match_word(input logic [1:0] kind, input logic [1:0] fid,
				input logic [7:0] tb, input logic last, input logic [28:0] total);
			result_t want;
			if (parsed_results.size() == 0) begin
				$display("%0t: result word with none expected: kind %0d field %0d byte %02h",
					$time, kind, fid, tb);
				errors++;
				return;
			end
			want = parsed_results.pop_front();
			cmp_field("result_kind", want.kind, kind);
			cmp_field("field_id", want.fid, fid);
			cmp_field("text_byte", want.tbyte, tb);
			cmp_field("frame_last", want.last, last);
			cmp_field("tag_total_size", want.total, total);
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  tag_byte = 8'h00;
	logic        first_byte = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  result_kind;
	logic [1:0]  field_id;
	logic [7:0]  text_byte;
	logic        frame_last;
	logic [28:0] tag_total_size;

	// Sender asks for one long receiver hold; calm turns all idling off near the end
	bit hold_request = 1'b0;
	bit calm = 1'b0;

	tag_parse_scoreboard sb;

	// Tag under construction, sent byte by byte
	logic [7:0] tag_q[$];

	id3v2_text_frame_extractor_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.tag_byte      (tag_byte),
		.first_byte    (first_byte),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.result_kind   (result_kind),
		.field_id      (field_id),
		.text_byte     (text_byte),
		.frame_last    (frame_last),
		.tag_total_size(tag_total_size)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Hard stop in case the block hangs or drops a word
	initial begin
		#5_000_000;
		$display("[id3v2_text_frame_extractor_core] ERROR");
		$finish;
	end

	// Result side: check every word that leaves the block, values as seen before the edge
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.match_word(result_kind, field_id, text_byte, frame_last, tag_total_size);
	end

	// Receiver: each pass sets out_stall once and holds it until the pass ends
	initial begin : receiver
		forever begin
			if (hold_request) begin
				// hold off long enough for the result queue to fill and push back on the input
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				hold_request = 1'b0;
			end else if (!calm && $urandom_range(0, 2) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end else begin
				out_stall <= 1'b0;
				repeat (calm ? 1 : $urandom_range(1, 16)) @(posedge clk);
			end
		end
	end

	// Pack a value into four 7-bit groups; junk sets random top bits the block must drop
	function automatic logic [31:0] to_synchsafe(input int unsigned v, input bit junk);
		logic [31:0] w;
		for (int i = 0; i < 4; i++)
			w[8 * i +: 8] = {junk ? 1'($urandom) : 1'b0, 7'(v >> (7 * i))};
		return w;
	endfunction

	function automatic void put_word(input logic [31:0] w);
		for (int i = 3; i >= 0; i--)
			tag_q.push_back(w[8 * i +: 8]);
	endfunction

	// Start a tag: identifier, random version bytes, flags, size left at zero
	function automatic void start_tag(input logic [7:0] flags);
		tag_q.delete();
		tag_q.push_back(8'h49);
		tag_q.push_back(8'h44);
		tag_q.push_back(8'h33);
		tag_q.push_back(8'($urandom));
		tag_q.push_back(8'($urandom));
		tag_q.push_back(flags);
		put_word(32'd0);
	endfunction

	function automatic void set_size(input int unsigned sz, input bit junk);
		logic [31:0] w;
		w = to_synchsafe(sz, junk);
		for (int i = 0; i < 4; i++)
			tag_q[6 + i] = w[8 * (3 - i) +: 8];
	endfunction

	// Frame with 'T', three id bytes, coded size, two flag bytes and len payload bytes
	function automatic void put_frame(input logic [23:0] id, input logic [31:0] coded,
			input int len, input logic [7:0] fl2, input int lead, input bit blank);
		tag_q.push_back(BYTE_T);
		for (int i = 2; i >= 0; i--)
			tag_q.push_back(id[8 * i +: 8]);
		put_word(coded);
		tag_q.push_back(8'($urandom));
		tag_q.push_back(fl2);
		for (int i = 0; i < len; i++)
			tag_q.push_back((blank || i < lead || $urandom_range(0, 5) == 0) ?
				8'h00 : 8'($urandom));
	endfunction

	// Build a mostly well-formed tag with random content; return the bytes it spans
	function automatic int build_random_tag();
		bit unsync, ext;
		int len, body, sz, extra;
		logic [7:0] fl2;
		logic [23:0] id;
		unsync = 1'($urandom);
		ext = ($urandom_range(0, 4) == 0);
		start_tag({unsync, ext, 6'($urandom)});
		if (ext) begin
			len = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 12);
			put_word(to_synchsafe(len, 1'($urandom)));
			for (int i = 4; i < len; i++)
				tag_q.push_back(8'($urandom));
		end
		repeat ($urandom_range(0, 4)) begin
			case ($urandom_range(0, 6))
				0, 1: id = ID_IT2;
				2, 3: id = ID_ALB;
				4: id = ID_PE1;
				5: id = 24'($urandom);
				default: id = ID_PE1 ^ (24'd1 << $urandom_range(0, 23));
			endcase
			// now and then a frame long enough to set bit 7 of a raw size byte
			len = ($urandom_range(0, 19) == 0) ? $urandom_range(128, 140) : $urandom_range(0, 10);
			fl2 = 8'($urandom);
			if ($urandom_range(0, 3) != 0)
				fl2 = fl2 & ~FLAG_SKIP;
			put_frame(id, unsync ? to_synchsafe(len, 1'($urandom)) : 32'(len), len, fl2,
				$urandom_range(0, 3), $urandom_range(0, 7) == 0);
		end
		body = tag_q.size() - 10;
		case ($urandom_range(0, 9))
			7: sz = (body > 0) ? body - $urandom_range(1, body) : 0;
			8: begin
				// padding or junk after the last frame
				extra = $urandom_range(1, 3);
				sz = body + extra;
				repeat (extra)
					tag_q.push_back($urandom_range(0, 1) ? 8'h00 : 8'($urandom));
			end
			9: sz = $urandom_range(body + 1, 28'hFFF_FFFF);
			default: sz = body;
		endcase
		set_size(sz, 1'($urandom));
		return sz + 10;
	endfunction

	// Offer one word and hold it until taken, with a random gap in front
	task automatic send_word(input logic [7:0] b, input logic f);
		if (!calm && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		in_valid <= 1'b1;
		tag_byte <= b;
		first_byte <= f;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.take_byte(b, f);
	endtask

	task automatic send_tag(input logic first, input int count);
		for (int i = 0; i < count; i++)
			send_word(tag_q[i], (i == 0) ? first : 1'b0);
	endtask

	// Stop offering and wait until every queued result has come out
	task automatic drain();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.pending() != 0);
	endtask

	initial begin : stimulus
		int span, cut;
		int unsigned done_items;
		bit paused;
		sb = new();
		done_items = 0;
		paused = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty tag right after reset, taken as offset 0 without the restart flag
		start_tag(8'h00);
		set_size(0, 1'b0);
		send_tag(1'b0, tag_q.size());

		// extended header flagged but the tag too short to hold its size
		start_tag(FLAG_EXT);
		set_size(3, 1'b1);
		send_tag(1'b1, tag_q.size());

		// extended header declaring less than its own size field
		start_tag(FLAG_EXT);
		put_word(to_synchsafe(2, 1'b1));
		set_size(10, 1'b0);
		send_tag(1'b1, tag_q.size());

		// extended header running past the tag end: complete where the tag ends
		start_tag(FLAG_EXT);
		put_word(to_synchsafe(20, 1'b0));
		tag_q.push_back(8'($urandom));
		tag_q.push_back(8'($urandom));
		set_size(6, 1'b0);
		send_tag(1'b1, tag_q.size());

		// extended header of exactly four bytes filling the whole tag
		start_tag(FLAG_EXT | HDR_UNSYNC_BIT);
		put_word(to_synchsafe(4, 1'b1));
		set_size(4, 1'b0);
		send_tag(1'b1, tag_q.size());

		// zero padding where a frame should start, then bytes the block must ignore
		start_tag(8'h00);
		put_word(32'd0);
		set_size(3, 1'b0);
		send_tag(1'b1, tag_q.size());

		// tag ending inside a frame header
		start_tag(8'h00);
		put_frame(ID_IT2, 32'd0, 0, 8'h00, 0, 1'b0);
		set_size(5, 1'b0);
		send_tag(1'b1, tag_q.size());

		// frame size reaching one byte past the tag end
		start_tag(8'h00);
		put_frame(ID_IT2, 32'd1, 1, 8'h00, 0, 1'b0);
		set_size(10, 1'b0);
		send_tag(1'b1, tag_q.size());

		// full tag: stripped text, all-zero field, skipped frames, empty field with complete
		start_tag(HDR_UNSYNC_BIT);
		put_frame(ID_IT2, to_synchsafe(8, 1'b1), 8, 8'h00, 2, 1'b0);
		put_frame(ID_ALB, to_synchsafe(3, 1'b1), 3, 8'h00, 0, 1'b1);
		put_frame(ID_IT2, to_synchsafe(2, 1'b0), 2, FL2_COMPRESSED, 0, 1'b0);
		put_frame(ID_PE1, to_synchsafe(2, 1'b0), 2, FL2_ENCRYPTED, 0, 1'b0);
		put_frame(ID_XXX, to_synchsafe(1, 1'b0), 1, 8'h00, 0, 1'b0);
		put_frame(ID_PE1, to_synchsafe(0, 1'b1), 0, 8'h00, 0, 1'b0);
		set_size(tag_q.size() - 10, 1'b1);
		hold_request = 1'b1;
		send_tag(1'b1, tag_q.size());

		// largest header size, then a raw frame size of all ones
		start_tag(8'h00);
		for (int i = 6; i < 10; i++)
			tag_q[i] = 8'hFF;
		put_frame(ID_ALB, 32'hFFFF_FFFF, 2, 8'h00, 0, 1'b0);
		send_tag(1'b1, tag_q.size());
		drain();

		while (done_items < ITEMS) begin
			if (done_items >= ITEMS * 9 / 10)
				calm = 1'b1;
			if (!paused && done_items >= ITEMS / 2) begin
				// pause until the block is empty, then hold the receiver while refilling
				drain();
				paused = 1'b1;
				hold_request = 1'b1;
			end
			if ($urandom_range(0, 19) == 0) begin
				// noise: random bytes, a few of them restarting the parse
				cut = $urandom_range(1, 20);
				repeat (cut)
					send_word(8'($urandom), $urandom_range(0, 7) == 0);
				done_items += cut;
			end else begin
				span = build_random_tag();
				// now and then cut the tag short and restart on the next one
				cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, tag_q.size()) : tag_q.size();
				send_tag(1'b1, cut);
				done_items += (cut < span) ? cut : span;
			end
		end

		drain();
		repeat (TAIL) @(posedge clk);
		if (sb.errors == 0)
			$display("[id3v2_text_frame_extractor_core] OK");
		else
			$display("[id3v2_text_frame_extractor_core] ERROR");
		$finish;
	end

endmodule
